>>> src/lpr_pkg.sv
// Package for the light pair plane reconstruction block.
// Holds payload word types, register indexes and reset constants.
// No dependencies.
package lpr_pkg;

  localparam int LPR_COORD_WIDTH = 16;
  localparam int LPR_FRAC_BITS   = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd1;

  localparam logic [15:0] FOCAL_RESET   = 16'd512;
  localparam logic [15:0] SPACING_RESET = 16'd1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_DEGEN = 1'b1;

  typedef struct packed {
    logic                              track_start;
    logic signed [LPR_COORD_WIDTH-1:0] left_img_x;
    logic signed [LPR_COORD_WIDTH-1:0] left_img_y;
    logic signed [LPR_COORD_WIDTH-1:0] right_img_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] left_world_x;
    logic signed [31:0] left_world_y;
    logic signed [31:0] left_world_z;
    logic signed [31:0] right_world_x;
    logic signed [31:0] right_world_y;
    logic signed [31:0] right_world_z;
    logic               status;
  } out_word_t;

endpackage

>>> src/lpr_div_lane.sv
// Bit-serial restoring divider lane: one quotient bit per step.
// Standalone; used by light_pair_plane_reconstruct.
module lpr_div_lane #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, acc_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_comb begin
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    if (load) begin
      acc_nxt = num_in;
      rem_nxt = '0;
    end else if (step) begin
      // shift in the next numerator bit, retire one quotient bit at the bottom
      acc_nxt = {acc_r[NUM_W-2:0], ge};
      rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign quo = acc_r;

endmodule

>>> src/light_pair_plane_reconstruct.sv
// Top level of the light pair plane reconstruction block.
// Depends on lpr_pkg and lpr_div_lane.
//
// Usage:
//   Input words (in_valid/in_stall) carry one frame: left x,y and right y of a
//   light pair. The block keeps the previous frame; a frame that starts a
//   track, or the first after reset, is stored and gives no result.
//   Every other frame gives one output word (out_valid/out_stall) holding the
//   Q24.8 world positions of the previous pair, each spacing * c / |d0|,
//   rounded and saturated. Zero d0, d1, dx or focal length gives status 1
//   with zero positions.
//   cfg_we/cfg_index/cfg_data write focal length (0) and spacing (1); others are
//   dropped. The user must write only while the block is idle; it has no check.
// Timing:
//   A frame with no result only updates the stored frame. A result frame is
//   multiplied as it is accepted and then loaded into the dividers, which
//   retire one quotient bit per cycle, four bit-serial lanes side by side
//   sharing the divisor. Degenerate frames skip the load and the division.
//   A finished word sits in the output register while the next frame is
//   accepted; if the receiver stalls, hold the next result until it drains.
// Reset:
//   Synchronous active-low rst_n clears the previous-frame flag, the output
//   valid and the state machine, and loads focal 512, spacing 1.
module light_pair_plane_reconstruct #(
  parameter int FRAC_BITS   = lpr_pkg::LPR_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lpr_pkg::in_word_t                   in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lpr_pkg::out_word_t                  out_word,
  input  logic                                cfg_we,
  input  logic [lpr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lpr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import lpr_pkg::*;

  localparam int CW    = LPR_COORD_WIDTH;
  localparam int MW    = (CW > 16) ? CW : 16;   // magnitude width (coords or focal)
  localparam int PW    = 16 + MW;               // spacing * magnitude
  localparam int NUM_W = PW + FRAC_BITS + 1;    // room for the rounding half
  localparam int DEN_W = CW + 1;                // |d0| up to 2^CW - 1
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int LANES = 4;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [15:0] focal_r, focal_nxt;
  logic [15:0] spacing_r, spacing_nxt;

  // previous frame
  logic signed [CW-1:0] prev_lx_r, prev_lx_nxt;
  logic signed [CW-1:0] prev_ly_r, prev_ly_nxt;
  logic signed [CW-1:0] prev_ry_r, prev_ry_nxt;
  logic                 have_prev_r, have_prev_nxt;

  // work registers
  logic [MW-1:0]    mag_r [LANES];
  logic [MW-1:0]    mag_nxt [LANES];
  logic             neg_r [LANES];
  logic             neg_nxt [LANES];
  logic [PW-1:0]    prod_r [LANES];
  logic [PW-1:0]    prod_nxt [LANES];
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             degen_r, degen_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_r, out_nxt;

  // current frame, taken at the internal coordinate width
  logic signed [CW-1:0] cur_x, cur_ly, cur_ry;
  logic signed [CW:0]   d0, d1, dx;
  logic                 accept, produce, degen;

  logic             lane_load, lane_step;
  logic [NUM_W-1:0] lane_num [LANES];
  logic [NUM_W-1:0] lane_quo [LANES];
  logic [31:0]      res [LANES];

  function automatic logic [MW-1:0] abs_coord(input logic signed [CW-1:0] c);
    logic [CW-1:0] m;
    m = c[CW-1] ? CW'(-c) : CW'(c);
    return MW'(m);
  endfunction

  function automatic logic [31:0] saturate(input logic [NUM_W-1:0] q, input logic neg);
    logic big;
    big = |q[NUM_W-1:31];
    if (neg) begin
      return big ? 32'h8000_0000 : (32'd0 - {1'b0, q[30:0]});
    end
    return big ? 32'h7FFF_FFFF : {1'b0, q[30:0]};
  endfunction

  assign cur_x  = CW'(in_word.left_img_x);
  assign cur_ly = CW'(in_word.left_img_y);
  assign cur_ry = CW'(in_word.right_img_y);

  assign d0 = (CW+1)'(prev_ly_r) - (CW+1)'(prev_ry_r);
  assign d1 = (CW+1)'(cur_ly) - (CW+1)'(cur_ry);
  assign dx = (CW+1)'(cur_x) - (CW+1)'(prev_lx_r);

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign produce  = !in_word.track_start && have_prev_r;
  assign degen    = (d0 == '0) || (d1 == '0) || (dx == '0) || (focal_r == '0);

  assign lane_load = (state_r == S_MUL);
  assign lane_step = (state_r == S_DIV);

  // lanes: previous left x, previous left y, focal length, previous right y
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign lane_num[i] = (NUM_W'(prod_r[i]) << FRAC_BITS) + NUM_W'(den_r >> 1);

    lpr_div_lane #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
    ) u_lane (
      .clk    (clk),
      .load   (lane_load),
      .step   (lane_step),
      .num_in (lane_num[i]),
      .den    (den_r),
      .quo    (lane_quo[i])
    );

    assign res[i] = saturate(lane_quo[i], neg_r[i]);
  end

  always_comb begin
    state_nxt     = state_r;
    focal_nxt     = focal_r;
    spacing_nxt   = spacing_r;
    prev_lx_nxt   = prev_lx_r;
    prev_ly_nxt   = prev_ly_r;
    prev_ry_nxt   = prev_ry_r;
    have_prev_nxt = have_prev_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    den_nxt       = den_r;
    degen_nxt     = degen_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_FOCAL:   focal_nxt   = cfg_data;
        REG_SPACING: spacing_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (produce) begin
            degen_nxt  = degen;
            den_nxt    = d0[CW] ? DEN_W'(-d0) : DEN_W'(d0);
            mag_nxt[0] = abs_coord(prev_lx_r);
            mag_nxt[1] = abs_coord(prev_ly_r);
            mag_nxt[2] = MW'(focal_r);
            mag_nxt[3] = abs_coord(prev_ry_r);
            neg_nxt[0] = prev_lx_r[CW-1];
            neg_nxt[1] = prev_ly_r[CW-1];
            neg_nxt[2] = 1'b0;
            neg_nxt[3] = prev_ry_r[CW-1];
            state_nxt  = degen ? S_DONE : S_MUL;
          end
          prev_lx_nxt   = cur_x;
          prev_ly_nxt   = cur_ly;
          prev_ry_nxt   = cur_ry;
          have_prev_nxt = 1'b1;
        end
      end
      S_MUL: begin
        // products are registered; load the lanes from them now
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to drain
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (degen_r) begin
            out_nxt        = '0;
            out_nxt.status = STATUS_DEGEN;
          end else begin
            out_nxt.left_world_x  = res[0];
            out_nxt.left_world_y  = res[1];
            out_nxt.left_world_z  = res[2];
            out_nxt.right_world_x = res[0];
            out_nxt.right_world_y = res[3];
            out_nxt.right_world_z = res[2];
            out_nxt.status        = STATUS_OK;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // multiply from the captured magnitudes; the lanes load them in S_MUL
    if (state_r == S_IDLE) begin
      for (int i = 0; i < LANES; i++) begin
        prod_nxt[i] = PW'(spacing_r) * PW'(mag_nxt[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      focal_r     <= FOCAL_RESET;
      spacing_r   <= SPACING_RESET;
      prev_lx_r   <= '0;
      prev_ly_r   <= '0;
      prev_ry_r   <= '0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      focal_r     <= focal_nxt;
      spacing_r   <= spacing_nxt;
      prev_lx_r   <= prev_lx_nxt;
      prev_ly_r   <= prev_ly_nxt;
      prev_ry_r   <= prev_ry_nxt;
      have_prev_r <= have_prev_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    prod_r  <= prod_nxt;
    den_r   <= den_nxt;
    degen_r <= degen_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

>>> src/lpr_checker.sv
// Port-level checker for light_pair_plane_reconstruct, bound to the top level.
// Depends on lpr_pkg.
module lpr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input lpr_pkg::out_word_t             out_word
);

  import lpr_pkg::*;

  // reset drops any pending word
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == STATUS_DEGEN |->
      out_word.left_world_x == 0 && out_word.left_world_y == 0 &&
      out_word.left_world_z == 0 && out_word.right_world_x == 0 &&
      out_word.right_world_y == 0 && out_word.right_world_z == 0)
    else $error("degenerate word with nonzero position");

  // both lights share image x and focal depth
  a_shared_axes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.left_world_x == out_word.right_world_x &&
                  out_word.left_world_z == out_word.right_world_z)
    else $error("left and right x or z differ");

endmodule

bind light_pair_plane_reconstruct lpr_checker u_lpr_checker (.*);

>>> dv/tb_top.sv
// Testbench for light_pair_plane_reconstruct: directed frame table, then random tracks.
// Depends on lpr_pkg and the block's RTL only; checks every output word against a
// built-in predictor of the world positions or a directed row's typed expectation.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;   // idle wait for a frame still in the block
  localparam int RANDOM_PER_SET = 250;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_word_t in_word;
  logic out_valid;
  logic out_stall;
  out_word_t out_word;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  light_pair_plane_reconstruct DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predictor state: registers and the stored previous frame.
  logic [15:0] focal_q;
  logic [15:0] spacing_q;
  logic signed [15:0] prev_x;
  logic signed [15:0] prev_ly;
  logic signed [15:0] prev_ry;
  bit have_prev;

  out_word_t pending_positions[$];
  int errors;
  int frames_sent;
  int words_checked;
  int degen_seen;
  int idle_cycles;
  bit quiet;        // no idling on either side
  int stall_left;

  // Scale one image coordinate onto the world: spacing * c * 2^8 / den,
  // rounded half away from zero, saturated to 32 bits.
  function automatic logic signed [31:0] world_coord(longint c, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    q = (longint'(spacing_q) * mag * (64'd1 << LPR_FRAC_BITS) + den / 2) / den;
    if (c < 0)
      return (q >= 64'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
    return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
  endfunction

  // Advance the predictor by one frame; return 1 when a result word is due.
  function automatic bit reconstruct_frame(in_word_t w, output out_word_t r);
    longint d0;
    longint d1;
    longint dx;
    longint unsigned den;
    bit due;
    r = '0;
    due = !w.track_start && have_prev;
    if (due) begin
      d0 = longint'(prev_ly) - longint'(prev_ry);
      d1 = longint'(w.left_img_y) - longint'(w.right_img_y);
      dx = longint'(w.left_img_x) - longint'(prev_x);
      if (d0 == 0 || d1 == 0 || dx == 0 || focal_q == 0) begin
        r.status = STATUS_DEGEN;
      end else begin
        den = (d0 < 0) ? longint'(-d0) : longint'(d0);
        r.left_world_x  = world_coord(prev_x, den);
        r.left_world_y  = world_coord(prev_ly, den);
        r.left_world_z  = world_coord(longint'(focal_q), den);
        r.right_world_x = world_coord(prev_x, den);
        r.right_world_y = world_coord(prev_ry, den);
        r.right_world_z = world_coord(longint'(focal_q), den);
        r.status = STATUS_OK;
      end
    end
    prev_x = w.left_img_x;
    prev_ly = w.left_img_y;
    prev_ry = w.right_img_y;
    have_prev = 1'b1;
    return due;
  endfunction

  // Register write; indexes beyond spacing are dropped by the block too.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == REG_FOCAL)
      focal_q = val;
    else if (idx == REG_SPACING)
      spacing_q = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Present one frame at the falling edge and hold it until accepted.
  // typed_due and typed_word override the predictor when use_typed is set.
  task automatic send_frame(in_word_t w, bit use_typed, bit typed_due, out_word_t typed_word);
    out_word_t r;
    bit due;
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word = w;
    due = reconstruct_frame(w, r);
    if (use_typed) begin
      if (typed_due != due)
        $display("%0t: predictor disagrees with directed row on result count", $time);
      due = typed_due;
      r = typed_word;
    end
    if (due)
      pending_positions.push_back(r);
    do @(posedge clk); while (in_stall);
    frames_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Hold off until every result has come, then let a silent frame finish.
  task automatic drain_block();
    while (pending_positions.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord(bit narrow);
    if (narrow)
      return 16'(signed'($urandom_range(0, 8)) - 4);
    return 16'($urandom());
  endfunction

  // Receiver side: random stall bursts, none while quiet.
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted output word, field by field, with the oldest expectation.
  always @(posedge clk) begin
    out_word_t e;
    logic [31:0] ef[7];
    logic [31:0] af[7];
    if (rst_n && out_valid && !out_stall) begin
      if (pending_positions.size() == 0) begin
        $display("%0t: unexpected output word %h", $time, out_word);
        errors++;
      end else begin
        e = pending_positions.pop_front();
        ef = '{e.left_world_x, e.left_world_y, e.left_world_z, e.right_world_x,
               e.right_world_y, e.right_world_z, 32'(e.status)};
        af = '{out_word.left_world_x, out_word.left_world_y, out_word.left_world_z,
               out_word.right_world_x, out_word.right_world_y, out_word.right_world_z,
               32'(out_word.status)};
        for (int i = 0; i < 7; i++) begin
          if (ef[i] !== af[i]) begin
            $display("%0t: field %0d mismatch expected %h actual %h", $time, i, ef[i], af[i]);
            errors++;
          end
        end
        words_checked++;
        if (e.status == STATUS_DEGEN)
          degen_seen++;
      end
    end
  end

  // Watchdog: count cycles with no word moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  typedef struct {
    in_word_t  w;
    bit        typed;   // expectation written in the row
    bit        due;
    out_word_t res;
  } frame_row_t;

  typedef struct {
    logic [15:0] focal;
    logic [15:0] spacing;
  } reg_set_t;

  initial begin
    frame_row_t rows[$];
    frame_row_t row;
    reg_set_t sets[$];
    in_word_t w;
    bit narrow;
    errors = 0;
    frames_sent = 0;
    words_checked = 0;
    degen_seen = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    focal_q = FOCAL_RESET;
    spacing_q = SPACING_RESET;
    prev_x = '0;
    prev_ly = '0;
    prev_ry = '0;
    have_prev = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed frames at reset settings (focal 512, spacing 1).
    // Track start: stored, no word.
    rows.push_back('{'{1'b1, 16'sd10, 16'sd4, 16'sd0}, 1'b1, 1'b0, '0});
    // d0 = 4: left (640, 256, 32768), right (640, 0, 32768).
    rows.push_back('{'{1'b0, 16'sd20, 16'sd2, 16'sd0}, 1'b1, 1'b1,
                     '{32'sd640, 32'sd256, 32'sd32768, 32'sd640, 32'sd0, 32'sd32768,
                       STATUS_OK}});
    // Same x as before: dx zero, degenerate.
    rows.push_back('{'{1'b0, 16'sd20, 16'sd5, 16'sd1}, 1'b1, 1'b1,
                     '{0, 0, 0, 0, 0, 0, STATUS_DEGEN}});
    // Coordinate extremes.
    rows.push_back('{'{1'b0, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, 1'b0, '0});
    rows.push_back('{'{1'b0, 16'sd32767, -16'sd32768, 16'sd32767}, 1'b0, 1'b0, '0});
    // Current d1 zero: degenerate.
    rows.push_back('{'{1'b0, 16'sd0, 16'sd5, 16'sd5}, 1'b1, 1'b1,
                     '{0, 0, 0, 0, 0, 0, STATUS_DEGEN}});
    // Previous d0 zero: degenerate.
    rows.push_back('{'{1'b0, 16'sd7, 16'sd9, 16'sd1}, 1'b1, 1'b1,
                     '{0, 0, 0, 0, 0, 0, STATUS_DEGEN}});
    rows.push_back('{'{1'b0, -16'sd3, -16'sd9, 16'sd8}, 1'b0, 1'b0, '0});
    // Track restart in the middle, then two more results.
    rows.push_back('{'{1'b1, 16'sd100, -16'sd1, 16'sd0}, 1'b1, 1'b0, '0});
    rows.push_back('{'{1'b0, -16'sd100, 16'sd3, -16'sd3}, 1'b0, 1'b0, '0});
    rows.push_back('{'{1'b0, 16'sd1, 16'sd0, -16'sd1}, 1'b0, 1'b0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_frame(row.w, row.typed, row.due, row.res);
    end

    // Saturation and the register extremes, each checked after an idle drain.
    sets.push_back('{16'd65535, 16'd65535});
    sets.push_back('{16'd1, 16'd1});
    sets.push_back('{16'd0, 16'd3});
    sets.push_back('{16'd300, 16'd0});
    sets.push_back('{16'd1000, 16'd7});
    sets.push_back('{16'(  $urandom_range(1, 65535)), 16'($urandom_range(1, 65535))});
    foreach (sets[s]) begin
      drain_block();   // sender pauses until every expected word is back
      write_reg(REG_FOCAL, sets[s].focal);
      write_reg(REG_SPACING, sets[s].spacing);
      write_reg(CFG_IDX_W'($urandom_range(2, 3)), 16'($urandom()));
      if (s == sets.size() - 1)
        quiet = 1'b1;
      // Short directed saturation hit on the large setting.
      if (s == 0) begin
        send_frame('{1'b1, -16'sd32768, 16'sd1, 16'sd0}, 1'b0, 1'b0, '0);
        send_frame('{1'b0, 16'sd5, 16'sd2, 16'sd0}, 1'b0, 1'b0, '0);
      end
      for (int n = 0; n < RANDOM_PER_SET; n++) begin
        narrow = ($urandom_range(0, 3) == 0);
        w.track_start = ($urandom_range(0, 15) == 0);
        w.left_img_x = rand_coord(narrow);
        w.left_img_y = rand_coord(narrow);
        w.right_img_y = rand_coord(narrow);
        send_frame(w, 1'b0, 1'b0, '0);
      end
    end

    while (pending_positions.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d frames over %0d register settings; checked %0d words, %0d degenerate.",
             frames_sent, sets.size() + 1, words_checked, degen_seen);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
src/lpr_pkg.sv
src/lpr_div_lane.sv
src/light_pair_plane_reconstruct.sv
src/lpr_checker.sv
dv/tb_top.sv
